// File: rtl/bb3c_pkg.sv
// Package for the clipped 3x3 box blur unit.
// Pixel, line store and window types, size constants and the reciprocal table
// used for the constant divisions. No dependencies.
`default_nettype none

package bb3c_pkg;

    localparam int MAX_SIDE    = 1024;
    localparam int ADDR_W      = $clog2(MAX_SIDE);
    localparam int POS_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int CH_W        = 16;
    localparam int SUM_W       = 20;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int WIN_CELLS   = 9;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t older;
        rgb_t newer;
    } line_entry_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic r_last;
        logic c_ge1;
        logic c_ge2;
        logic c_last;
    } pos_flags_t;

    // floor(x / count) == (x * recip) >> RECIP_SHIFT for every reachable sum
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        begin
            case (count)
                CNT_W'(2):  m = RECIP_W'(24'd4194304);
                CNT_W'(3):  m = RECIP_W'(24'd2796203);
                CNT_W'(4):  m = RECIP_W'(24'd2097152);
                CNT_W'(6):  m = RECIP_W'(24'd1398102);
                CNT_W'(9):  m = RECIP_W'(24'd932068);
                default:    m = RECIP_W'(24'd8388608);
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/box_blur_3x3_clipped_unit.sv
// Clipped 3x3 box blur over a square RGB image streamed in raster order.
// Depends on bb3c_pkg (types, size constants, reciprocal table).
// Line stores live in one synchronous RAM read and written back per pixel.
`default_nettype none

// Usage:
//   Input channel: in_valid / in_stall with red_in, green_in, blue_in, one
//   pixel per request in raster order. Output channel: out_valid / out_stall
//   with the three channel means, out_row, out_col, last_of_run (last result
//   caused by one input) and end_of_frame (pixel n-1, n-1).
//   cfg_we / cfg_wdata write the image side (0 acts as 1, above 1024 as 1024)
//   and restart the raster position at row 0, column 0; write only when idle.
//   Results trail the input by one row and one column; the last pixel of a
//   frame flushes the remaining ones. Each input causes 0 to 4 results.
//   A result passes stage 1, stage 2, stage 3 and the output register.
//   Throughput: one input per cycle while each input causes at most one
//   result and the output is not stalled; else the input is held, as the
//   single window-sum stage issues one result per cycle while stage 3 is free.
//   Reset: window cleared, position 0/0, side 32. The line store RAM is not
//   cleared; its stale entries only reach clipped window cells.
//   A stalled output holds its result; internal stages keep filling until full,
//   then in_stall rises.
module box_blur_3x3_clipped_unit
    import bb3c_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CH_W-1:0]   red_in,
    input  wire logic [CH_W-1:0]   green_in,
    input  wire logic [CH_W-1:0]   blue_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CH_W-1:0]        red_out,
    output logic [CH_W-1:0]        green_out,
    output logic [CH_W-1:0]        blue_out,
    output logic [POS_W-1:0]       out_row,
    output logic [POS_W-1:0]       out_col,
    output logic                   last_of_run,
    output logic                   end_of_frame
);

    // configuration and raster position
    logic [SIZE_W-1:0] size_reg;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [SIZE_W-1:0] size_m1;
    logic [POS_W-1:0]  nm1;
    pos_flags_t        flags_in;

    // stage 1: line store read in flight
    logic              s1_valid_reg, s1_valid_next;
    rgb_t              s1_px_reg;
    logic [POS_W-1:0]  s1_row_reg, s1_col_reg;
    pos_flags_t        s1_flags_reg;
    line_entry_t       rd_entry_reg;
    logic              fwd_hit_reg;
    line_entry_t       fwd_entry_reg;
    line_entry_t       s1_entry;
    line_entry_t       wr_entry;
    logic              s1_move;
    logic              accept;

    line_entry_t       line_mem [MAX_SIDE];

    // stage 2: window and result sequencing
    rgb_t              win_reg [WIN_CELLS];
    logic [3:0]        pend_reg, pend_next;
    logic [POS_W-1:0]  s2_row_reg, s2_col_reg;
    pos_flags_t        s2_flags_reg;
    logic [3:0]        sel_oh;
    logic [3:0]        pend_rest;
    logic              issue;
    logic              s2_take;
    logic              sel_top, sel_left;
    logic [2:0]        row_mask, col_mask;
    logic [1:0]        row_cnt, col_cnt;
    logic [CNT_W-1:0]  cell_cnt;
    sum_t              sum_sel;
    logic [POS_W-1:0]  orow_sel, ocol_sel;

    // stage 3: sums ready for scaling
    logic              s3_valid_reg, s3_valid_next;
    sum_t              s3_sum_reg;
    logic [RECIP_W-1:0] s3_recip_reg;
    logic [POS_W-1:0]  s3_row_reg, s3_col_reg;
    logic              s3_last_reg, s3_eof_reg;
    logic              s3_free;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   red_reg, green_reg, blue_reg;
    logic [POS_W-1:0]  orow_reg, ocol_reg;
    logic              last_reg, eof_reg;
    logic              out_load;
    logic [PROD_W-1:0] prod_red, prod_green, prod_blue;

    // ---------------------------------------------------------------- control
    always_comb
    begin
        size_m1 = size_reg - SIZE_W'(1);
        if (size_reg == '0)
            nm1 = '0;
        else if (size_reg > SIZE_W'(MAX_SIDE))
            nm1 = POS_W'(MAX_SIDE - 1);
        else
            nm1 = size_m1[POS_W-1:0];
    end

    assign out_load  = !out_valid_reg || !out_stall;
    assign s3_free   = !s3_valid_reg || out_load;
    assign issue     = (pend_reg != '0) && s3_free;
    assign sel_oh    = pend_reg & (~pend_reg + 4'd1);
    assign pend_rest = pend_reg & ~sel_oh;
    assign s2_take   = (pend_reg == '0) || (issue && (pend_rest == '0));
    assign s1_move   = s1_valid_reg && s2_take;
    assign in_stall  = s1_valid_reg && !s1_move;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        flags_in.r_ge1  = (row_reg != '0);
        flags_in.r_ge2  = (row_reg[POS_W-1:1] != '0);
        flags_in.r_last = (row_reg == nm1);
        flags_in.c_ge1  = (col_reg != '0);
        flags_in.c_ge2  = (col_reg[POS_W-1:1] != '0);
        flags_in.c_last = (col_reg == nm1);

        col_next = col_reg;
        row_next = row_reg;
        if (flags_in.c_last)
        begin
            col_next = '0;
            row_next = flags_in.r_last ? '0 : row_reg + POS_W'(1);
        end
        else
        begin
            col_next = col_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------------------------------------------------------- stage 1
    assign s1_entry       = fwd_hit_reg ? fwd_entry_reg : rd_entry_reg;
    assign wr_entry.older = s1_entry.newer;
    assign wr_entry.newer = s1_px_reg;
    assign s1_valid_next  = accept || (s1_valid_reg && !s1_move);

    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_mem[s1_col_reg[ADDR_W-1:0]] <= wr_entry;
        if (accept)
            rd_entry_reg <= line_mem[col_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // same-column write in the read cycle: forward it (single-column frames)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg     <= '{red: red_in, green: green_in, blue: blue_in};
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_flags_reg  <= flags_in;
            fwd_hit_reg   <= s1_move && (s1_col_reg == col_reg);
            fwd_entry_reg <= wr_entry;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        pend_next = pend_reg;
        if (s1_move)
        begin
            pend_next[0] = s1_flags_reg.r_ge1  && s1_flags_reg.c_ge1;
            pend_next[1] = s1_flags_reg.r_ge1  && s1_flags_reg.c_last;
            pend_next[2] = s1_flags_reg.r_last && s1_flags_reg.c_ge1;
            pend_next[3] = s1_flags_reg.r_last && s1_flags_reg.c_last;
        end
        else if (issue)
        begin
            pend_next = pend_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            for (int i = 0; i < WIN_CELLS; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (s1_move)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= s1_entry.older;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= s1_entry.newer;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // top: result row is r-1; left: result column is c-1
    always_comb
    begin
        sel_top  = sel_oh[0] || sel_oh[1];
        sel_left = sel_oh[0] || sel_oh[2];

        row_mask = sel_top ? {1'b1, 1'b1, s2_flags_reg.r_ge2}
                           : {1'b1, s2_flags_reg.r_ge1, 1'b0};
        col_mask = sel_left ? {1'b1, 1'b1, s2_flags_reg.c_ge2}
                            : {1'b1, s2_flags_reg.c_ge1, 1'b0};

        row_cnt = sel_top ? (s2_flags_reg.r_ge2 ? 2'd3 : 2'd2)
                          : (s2_flags_reg.r_ge1 ? 2'd2 : 2'd1);
        col_cnt = sel_left ? (s2_flags_reg.c_ge2 ? 2'd3 : 2'd2)
                           : (s2_flags_reg.c_ge1 ? 2'd2 : 2'd1);
        cell_cnt = {2'b00, row_cnt} * {2'b00, col_cnt};

        orow_sel = sel_top  ? s2_row_reg - POS_W'(1) : s2_row_reg;
        ocol_sel = sel_left ? s2_col_reg - POS_W'(1) : s2_col_reg;

        sum_sel = '0;
        for (int wr = 0; wr < 3; wr++)
        begin
            for (int wc = 0; wc < 3; wc++)
            begin
                if (row_mask[wr] && col_mask[wc])
                begin
                    sum_sel.red   = sum_sel.red   + SUM_W'(win_reg[wr * 3 + wc].red);
                    sum_sel.green = sum_sel.green + SUM_W'(win_reg[wr * 3 + wc].green);
                    sum_sel.blue  = sum_sel.blue  + SUM_W'(win_reg[wr * 3 + wc].blue);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    assign s3_valid_next = issue || (s3_valid_reg && !out_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s3_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s3_sum_reg   <= sum_sel;
            s3_recip_reg <= recip_of(cell_cnt);
            s3_row_reg   <= orow_sel;
            s3_col_reg   <= ocol_sel;
            s3_last_reg  <= (pend_rest == '0);
            s3_eof_reg   <= sel_oh[3];
        end
    end

    // ---------------------------------------------------------------- output
    assign prod_red       = s3_sum_reg.red   * s3_recip_reg;
    assign prod_green     = s3_sum_reg.green * s3_recip_reg;
    assign prod_blue      = s3_sum_reg.blue  * s3_recip_reg;
    assign out_valid_next = s3_valid_reg || (out_valid_reg && !out_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s3_valid_reg)
        begin
            red_reg   <= prod_red[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            green_reg <= prod_green[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            blue_reg  <= prod_blue[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            orow_reg  <= s3_row_reg;
            ocol_reg  <= s3_col_reg;
            last_reg  <= s3_last_reg;
            eof_reg   <= s3_eof_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;
    assign last_of_run  = last_reg;
    assign end_of_frame = eof_reg;

endmodule

`default_nettype wire

// File: tb/bb3c_blur_checker.sv
// Scoreboard for box_blur_3x3_clipped_unit: follows the config and both request
// channels, predicts every smoothed pixel and compares it field by field.
// Depends on bb3c_pkg for sizes and the rgb_t pixel type.
`timescale 1ns / 1ps

module bb3c_blur_checker
    import bb3c_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [CH_W-1:0]   red_in,
    input  wire logic [CH_W-1:0]   green_in,
    input  wire logic [CH_W-1:0]   blue_in,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [CH_W-1:0]   red_out,
    input  wire logic [CH_W-1:0]   green_out,
    input  wire logic [CH_W-1:0]   blue_out,
    input  wire logic [POS_W-1:0]  out_row,
    input  wire logic [POS_W-1:0]  out_col,
    input  wire logic              last_of_run,
    input  wire logic              end_of_frame,
    output int                     miss_count,
    output int                     due_count
);

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic             eof;
    } blur_px_t;

    rgb_t              older_line [MAX_SIDE];
    rgb_t              newer_line [MAX_SIDE];
    rgb_t              win [WIN_CELLS];
    int                at_row = 0;
    int                at_col = 0;
    logic [SIZE_W-1:0] side_reg = SIZE_RESET;
    blur_px_t          blur_due [$];
    int                misses = 0;
    int                due_now = 0;

    assign miss_count = misses;
    assign due_count  = due_now;

    initial
    begin
        foreach (older_line[i])
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
    end

    function automatic int side_of(logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_SIDE)
            return MAX_SIDE;
        return int'(v);
    endfunction

    // window cell (wr, wc) holds the pixel at (r-2+wr, c-2+wc)
    function automatic blur_px_t mean_at(int orow, int ocol, int r, int c, int n, bit last);
        blur_px_t res;
        int sr, sg, sb, cnt, pr, pc, wr, wc;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (wr = 0; wr < 3; wr++)
        begin
            pr = r - 2 + wr;
            if (pr < 0 || pr >= n || pr < orow - 1 || pr > orow + 1)
                continue;
            for (wc = 0; wc < 3; wc++)
            begin
                pc = c - 2 + wc;
                if (pc < 0 || pc >= n || pc < ocol - 1 || pc > ocol + 1)
                    continue;
                sr += int'(win[wr * 3 + wc].red);
                sg += int'(win[wr * 3 + wc].green);
                sb += int'(win[wr * 3 + wc].blue);
                cnt++;
            end
        end
        if (cnt == 0)
            cnt = 1;
        res.red   = CH_W'(sr / cnt);
        res.green = CH_W'(sg / cnt);
        res.blue  = CH_W'(sb / cnt);
        res.row   = POS_W'(orow);
        res.col   = POS_W'(ocol);
        res.last  = last;
        res.eof   = (orow == n - 1) && (ocol == n - 1);
        return res;
    endfunction

    task automatic take_pixel(input rgb_t px);
        int n, r, c, k, cnt, wr;
        int orow [4];
        int ocol [4];
        begin
            n = side_of(side_reg);
            r = (at_row >= n) ? 0 : at_row;
            c = (at_col >= n) ? 0 : at_col;
            for (wr = 0; wr < 3; wr++)
            begin
                win[wr * 3]     = win[wr * 3 + 1];
                win[wr * 3 + 1] = win[wr * 3 + 2];
            end
            win[2] = older_line[c];
            win[5] = newer_line[c];
            win[8] = px;
            older_line[c] = newer_line[c];
            newer_line[c] = px;

            cnt = 0;
            if (r >= 1 && c >= 1)
            begin
                orow[cnt] = r - 1; ocol[cnt] = c - 1; cnt++;
            end
            if (r >= 1 && c == n - 1)
            begin
                orow[cnt] = r - 1; ocol[cnt] = c; cnt++;
            end
            if (r == n - 1 && c >= 1)
            begin
                orow[cnt] = r; ocol[cnt] = c - 1; cnt++;
            end
            if (r == n - 1 && c == n - 1)
            begin
                orow[cnt] = r; ocol[cnt] = c; cnt++;
            end
            for (k = 0; k < cnt; k++)
                blur_due.push_back(mean_at(orow[k], ocol[k], r, c, n, k == cnt - 1));

            if (c + 1 >= n)
            begin
                at_col = 0;
                at_row = (r + 1 >= n) ? 0 : r + 1;
            end
            else
            begin
                at_col = c + 1;
                at_row = r;
            end
        end
    endtask

    task automatic note_miss(input string msg);
        begin
            $display("%0t ns  %s", $time, msg);
            misses++;
        end
    endtask

    task automatic cmp_field(input string name, input int got, input int want,
                             input blur_px_t ref_px);
        begin
            if (got != want)
                note_miss($sformatf("%s at (%0d,%0d): got %0d, want %0d",
                                    name, ref_px.row, ref_px.col, got, want));
        end
    endtask

    task automatic check_result();
        blur_px_t want;
        begin
            if (blur_due.size() == 0)
                note_miss($sformatf("unexpected result at (%0d,%0d)", out_row, out_col));
            else
            begin
                want = blur_due.pop_front();
                cmp_field("red_out", red_out, want.red, want);
                cmp_field("green_out", green_out, want.green, want);
                cmp_field("blue_out", blue_out, want.blue, want);
                cmp_field("out_row", out_row, want.row, want);
                cmp_field("out_col", out_col, want.col, want);
                cmp_field("last_of_run", last_of_run, want.last, want);
                cmp_field("end_of_frame", end_of_frame, want.eof, want);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (win[i])
                win[i] = '0;
            at_row   = 0;
            at_col   = 0;
            side_reg = SIZE_RESET;
            blur_due.delete();
            due_now <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                side_reg = cfg_wdata;
                at_row   = 0;
                at_col   = 0;
            end
            if (in_valid && !in_stall)
                take_pixel(rgb_t'({red_in, green_in, blue_in}));
            if (out_valid && !out_stall)
                check_result();
            due_now <= blur_due.size();
        end
    end

endmodule

// File: tb/tb_box_blur_3x3_clipped_unit.sv
// Top of the box_blur_3x3_clipped_unit testbench: clock, reset, image size writes,
// pixel requests with random gaps and output stalls, watchdog and verdict.
// Depends on bb3c_pkg, the unit itself and bb3c_blur_checker.
`timescale 1ns / 1ps

module tb_box_blur_3x3_clipped_unit
    import bb3c_pkg::*;
;

    typedef enum int {PIX_ANY, PIX_RAIL, PIX_MIXED} pix_style_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 260;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic [CH_W-1:0]   red_in    = '0;
    logic [CH_W-1:0]   green_in  = '0;
    logic [CH_W-1:0]   blue_in   = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              last_of_run;
    logic              end_of_frame;

    int miss_total;
    int due_total;
    bit in_steady   = 1'b0;
    bit out_steady  = 1'b0;
    int hold_left   = 0;
    int next_hold   = 0;
    int quiet_count = 0;

    always #5 clk = ~clk;

    box_blur_3x3_clipped_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

    bb3c_blur_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .miss_count   (miss_total),
        .due_count    (due_total)
    );

    // output stall: fresh hold drawn after every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                next_hold = out_steady ? 0 : $urandom_range(0, 18);
            else
                next_hold = (hold_left > 0) ? hold_left - 1 : 0;
            hold_left <= next_hold;
            out_stall <= (next_hold != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count <= 0;
        else if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("box_blur_3x3_clipped_unit: mismatch");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    function automatic int pick_gap();
        if (in_steady)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [CH_W-1:0] pick_chan(pix_style_t style);
        logic rail;
        rail = ($urandom_range(0, 1) != 0);
        if (style == PIX_RAIL || (style == PIX_MIXED && $urandom_range(0, 2) == 0))
            return rail ? {CH_W{1'b1}} : {CH_W{1'b0}};
        return CH_W'($urandom_range(0, 65535));
    endfunction

    task automatic push_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int gap;
        begin
            gap = pick_gap();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            red_in   <= r;
            green_in <= g;
            blue_in  <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic write_side(input logic [SIZE_W-1:0] v);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // drain all pending results, then let rows that emit nothing clear the pipe
    task automatic settle();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (due_total != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count, input pix_style_t style);
        int i;
        begin
            for (i = 0; i < count; i++)
                push_pixel(pick_chan(style), pick_chan(style), pick_chan(style));
        end
    endtask

    initial
    begin
        int sent;
        int sel;
        int n;
        int count;
        logic [SIZE_W-1:0] side;
        pix_style_t style;

        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size left at its reset value
        run_random(70, PIX_MIXED);
        settle();

        // size zero acts as a 1x1 image
        write_side('0);
        push_pixel(16'hFFFF, 16'h0000, 16'h1234);
        push_pixel(16'h0000, 16'hFFFF, 16'h8001);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();
        write_side(SIZE_W'(1));
        push_pixel(16'hAAAA, 16'h5555, 16'h0001);
        settle();

        // 2x2: corners only, two frames back to back
        write_side(SIZE_W'(2));
        repeat (4) push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pixel(16'h0000, 16'hFFFF, 16'h0003);
        push_pixel(16'hFFFF, 16'h0000, 16'h0002);
        push_pixel(16'h0001, 16'hFFFE, 16'h0000);
        push_pixel(16'h0000, 16'h0000, 16'hFFFF);
        settle();

        // 3x3: restart mid-frame, then one full frame with an interior pixel
        write_side(SIZE_W'(3));
        repeat (5) push_pixel(16'h7FFF, 16'h8000, 16'hFFFF);
        settle();
        write_side(SIZE_W'(3));
        push_pixel(16'hFFFF, 16'h0000, 16'h0001);
        push_pixel(16'hFFFE, 16'h0001, 16'h0002);
        push_pixel(16'hFFFD, 16'h0002, 16'h0003);
        push_pixel(16'h0000, 16'hFFFF, 16'h0004);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pixel(16'h0000, 16'hFFFF, 16'h0006);
        push_pixel(16'h1111, 16'h2222, 16'h0007);
        push_pixel(16'h3333, 16'h4444, 16'h0008);
        push_pixel(16'h5555, 16'h6666, 16'h0009);
        settle();

        while (sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 11);
            if (sel == 0)
                side = '0;
            else if (sel == 1)
                side = SIZE_W'($urandom_range(13, 40));
            else if (sel == 2)
                side = SIZE_W'($urandom_range(MAX_SIDE + 1, 2047));
            else
                side = SIZE_W'($urandom_range(1, 10));
            n = (side == '0) ? 1 : ((int'(side) > MAX_SIDE) ? MAX_SIDE : int'(side));

            if (sel == 1)
                count = $urandom_range(n, 3 * n + 3);
            else if (sel == 2)
                count = $urandom_range(1, 30);
            else if ($urandom_range(0, 3) != 0)
                count = n * n * $urandom_range(1, 2);
            else
                count = $urandom_range(1, 2 * n * n + n);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;

            style      = pix_style_t'($urandom_range(0, 2));
            in_steady  = ($urandom_range(0, 4) == 0);
            out_steady = ($urandom_range(0, 4) == 0);
            write_side(side);
            run_random(count, style);
            settle();
            sent += count;
        end

        // largest legal side, a short stretch only
        in_steady  = 1'b0;
        out_steady = 1'b0;
        write_side(SIZE_W'(MAX_SIDE));
        run_random(20, PIX_ANY);
        settle();

        // clamped side, a short stretch only
        in_steady = 1'b1;
        write_side({SIZE_W{1'b1}});
        run_random(30, PIX_MIXED);
        settle();

        repeat (10) @(posedge clk);
        if (miss_total == 0)
            $display("box_blur_3x3_clipped_unit: match");
        else
            $display("box_blur_3x3_clipped_unit: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/bb3c_pkg.sv
rtl/box_blur_3x3_clipped_unit.sv
tb/bb3c_blur_checker.sv
tb/tb_box_blur_3x3_clipped_unit.sv
